### hdl/rlehl_pkg.sv
// Shared constants and types for the run-length bitmap to horizontal-line decoder.
package rlehl_pkg;

  // Width of the image column counter and of the screen coordinate arithmetic.
  localparam int COLUMN_BITS = 10;
  localparam int COORD_BITS  = 16;

  // Fixed field widths of the ports.
  localparam int BYTE_BITS    = 8;
  localparam int COORD_W      = 16;
  localparam int COLOUR_W     = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_W   = 16;

  // Narrowest usable image width.
  localparam int MIN_WIDTH = 8;

  // Width of the run length / segment compare path.
  localparam int SEG_W = (COLUMN_BITS > BYTE_BITS) ? COLUMN_BITS : BYTE_BITS;
  localparam int SUM_W = SEG_W + 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ORIGIN_X    = 3'd0,
    CFG_ORIGIN_Y    = 3'd1,
    CFG_IMAGE_WIDTH = 3'd2,
    CFG_RUN_FORMAT  = 3'd3,
    CFG_FG_COLOUR   = 3'd4
  } cfg_idx_t;

  // Run coding formats.
  typedef enum logic [1:0] {
    FMT_PAIR      = 2'd0,
    FMT_ALT_CLEAR = 2'd1,
    FMT_ALT_SET   = 2'd2,
    FMT_NONE      = 2'd3
  } run_fmt_t;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WRAP = 3'b010,
    ST_RUN  = 3'b100
  } state_t;

endpackage

### hdl/rle_bitmap_to_hline_decoder.sv
// Run-length one-bit image decoder that turns coded bytes into horizontal-line draw requests.
//
// Usage: coded image bytes enter on the in_ channel (in_valid / in_stall), one byte per
// request, with in_image_start high on the first byte of an image. Each set run leaves as
// one or more segment requests on the out_ channel (out_valid / out_stall); out_seg_last
// marks the final segment caused by a byte. Configuration registers are written through
// cfg_valid / cfg_ready with cfg_index and cfg_wdata, and only while the decoder is idle.
//
// Sequence: a value byte of pair format, or any byte in format none, is only accepted. A run
// byte is accepted, then its column is checked against the width, then it takes one pass
// of the shared subtract / compare unit per row piece it covers (at most 33 pieces). The
// first segment appears in the cycle after its piece is computed. The input side is
// stalled while a run is being worked through.
//
// Reset (rst_n low, synchronous) returns the registers to their defaults, clears the
// column, row and phase, and empties the output register. When the receiver stalls, the
// segment in the output register holds and a set run pauses until that register is free;
// clear runs keep going since they produce no segments.
module rle_bitmap_to_hline_decoder (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Coded byte input.
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [rlehl_pkg::BYTE_BITS-1:0]        in_data_byte,
  input  logic                                   in_image_start,
  // Segment output.
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [rlehl_pkg::COORD_W-1:0]          out_seg_x,
  output logic [rlehl_pkg::COORD_W-1:0]          out_seg_y,
  output logic [rlehl_pkg::BYTE_BITS-1:0]        out_seg_length,
  output logic [rlehl_pkg::COLOUR_W-1:0]         out_seg_colour,
  output logic                                   out_seg_last,
  // Configuration writes.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rlehl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [rlehl_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  import rlehl_pkg::*;

  // Configuration registers.
  logic [COORD_W-1:0]     origin_x_r;
  logic [COORD_W-1:0]     origin_y_r;
  logic [COLUMN_BITS-1:0] width_r;
  run_fmt_t               format_r;
  logic [COLOUR_W-1:0]    colour_r;

  // Decoder state.
  state_t                 state_r, state_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0]  row_r, row_nxt;
  logic                   expect_r, expect_nxt;
  logic                   pending_r, pending_nxt;
  logic                   cur_r, cur_nxt;
  logic [BYTE_BITS-1:0]   len_r, len_nxt;
  logic                   set_r, set_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]     out_x_r, out_x_nxt;
  logic [COORD_W-1:0]     out_y_r, out_y_nxt;
  logic [BYTE_BITS-1:0]   out_len_r, out_len_nxt;
  logic [COLOUR_W-1:0]    out_colour_r, out_colour_nxt;
  logic                   out_last_r, out_last_nxt;

  // Datapath of the shared step unit.
  logic [COLUMN_BITS-1:0] w_eff;
  logic [COLUMN_BITS-1:0] rem;
  logic [SEG_W-1:0]       len_ext, rem_ext, seg_ext;
  logic [BYTE_BITS-1:0]   seg;
  logic [SUM_W-1:0]       col_sum;
  logic                   row_end;
  logic [BYTE_BITS-1:0]   len_left;
  logic                   out_free;
  logic                   in_fire;
  logic                   start_cur;

  // An image width below the minimum is treated as the minimum.
  assign w_eff = (width_r < COLUMN_BITS'(MIN_WIDTH)) ? COLUMN_BITS'(MIN_WIDTH) : width_r;

  // One piece of a run: the shorter of what is left of the row and what is left of the run.
  assign rem      = w_eff - col_r;
  assign len_ext  = SEG_W'(len_r);
  assign rem_ext  = SEG_W'(rem);
  assign seg_ext  = (len_ext < rem_ext) ? len_ext : rem_ext;
  assign seg      = seg_ext[BYTE_BITS-1:0];
  assign col_sum  = SUM_W'(col_r) + SUM_W'(seg);
  assign row_end  = (col_sum == SUM_W'(w_eff));
  assign len_left = len_r - seg;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign start_cur = (format_r == FMT_ALT_SET);

  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    expect_nxt     = expect_r;
    pending_nxt    = pending_r;
    cur_nxt        = cur_r;
    len_nxt        = len_r;
    set_nxt        = set_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_len_nxt    = out_len_r;
    out_colour_nxt = out_colour_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_image_start) begin
            col_nxt     = '0;
            row_nxt     = '0;
            expect_nxt  = 1'b0;
            pending_nxt = 1'b0;
            cur_nxt     = start_cur;
          end
          len_nxt = in_data_byte;
          case (format_r)
            FMT_PAIR: begin
              // The first byte of a pair picks the colour, the second is the run.
              if (!expect_nxt) begin
                pending_nxt = (in_data_byte == BYTE_BITS'(1));
                expect_nxt  = 1'b1;
              end else begin
                set_nxt    = pending_nxt;
                expect_nxt = 1'b0;
                state_nxt  = ST_WRAP;
              end
            end
            FMT_ALT_CLEAR, FMT_ALT_SET: begin
              set_nxt   = cur_nxt;
              cur_nxt   = !cur_nxt;
              state_nxt = ST_WRAP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WRAP: begin
        // A column left past the edge by a narrowed width starts the next row.
        if (col_r >= w_eff) begin
          col_nxt = '0;
          row_nxt = row_r + COORD_BITS'(1);
        end
        state_nxt = (len_r == '0) ? ST_IDLE : ST_RUN;
      end
      ST_RUN: begin
        if (!set_r || out_free) begin
          len_nxt = len_left;
          if (row_end) begin
            col_nxt = '0;
            row_nxt = row_r + COORD_BITS'(1);
          end else begin
            col_nxt = col_sum[COLUMN_BITS-1:0];
          end
          if (set_r) begin
            out_valid_nxt  = 1'b1;
            out_x_nxt      = COORD_W'(COORD_BITS'(origin_x_r) + COORD_BITS'(col_r));
            out_y_nxt      = COORD_W'(COORD_BITS'(origin_y_r) + row_r);
            out_len_nxt    = seg;
            out_colour_nxt = colour_r;
            out_last_nxt   = (len_left == '0);
          end
          if (len_left == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      expect_r    <= 1'b0;
      pending_r   <= 1'b0;
      cur_r       <= 1'b0;
      len_r       <= '0;
      set_r       <= 1'b0;
      out_valid_r <= 1'b0;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      width_r     <= COLUMN_BITS'(MIN_WIDTH);
      format_r    <= FMT_NONE;
      colour_r    <= '1;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      expect_r    <= expect_nxt;
      pending_r   <= pending_nxt;
      cur_r       <= cur_nxt;
      len_r       <= len_nxt;
      set_r       <= set_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ORIGIN_X:    origin_x_r <= cfg_wdata;
          CFG_ORIGIN_Y:    origin_y_r <= cfg_wdata;
          CFG_IMAGE_WIDTH: width_r    <= cfg_wdata[COLUMN_BITS-1:0];
          CFG_RUN_FORMAT:  format_r   <= run_fmt_t'(cfg_wdata[1:0]);
          CFG_FG_COLOUR:   colour_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Segment payload carries no reset.
  always_ff @(posedge clk) begin
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_len_r    <= out_len_nxt;
    out_colour_r <= out_colour_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_seg_x      = out_x_r;
  assign out_seg_y      = out_y_r;
  assign out_seg_length = out_len_r;
  assign out_seg_colour = out_colour_r;
  assign out_seg_last   = out_last_r;

`ifndef SYNTHESIS
  // While pieces are being cut, the column stays inside the row.
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (col_r < w_eff))
    else $error("column reached the row edge during a run");

  // A segment never has zero length.
  a_seg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r != '0))
    else $error("zero-length segment presented");

  // New segments are only produced by a run step.
  a_seg_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || !out_stall) && !(state_r == ST_RUN && set_r) |=> !out_valid_r)
    else $error("segment appeared outside a set run");

  // The run step finishes a run exactly when its length is used up.
  a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (!set_r || out_free) && (len_left == '0) |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle at run end");
`endif

endmodule
